FILE: design/eafd_pkg.sv
// Shared types and constants for the Easter and feast date core.
package eafd_pkg;

    localparam int YEAR_W  = 14;
    localparam int DOY_W   = 8;
    localparam int MONTH_W = 3;
    localparam int DAY_W   = 5;

    typedef logic [YEAR_W-1:0]  year_t;
    typedef logic [DOY_W-1:0]   doy_t;
    typedef logic [MONTH_W-1:0] month_t;
    typedef logic [DAY_W-1:0]   day_t;

    typedef struct packed {
        month_t month;
        day_t   day;
    } md_t;

    // month codes
    localparam month_t MONTH_JAN = 3'd1;
    localparam month_t MONTH_FEB = 3'd2;
    localparam month_t MONTH_MAR = 3'd3;
    localparam month_t MONTH_APR = 3'd4;
    localparam month_t MONTH_MAY = 3'd5;
    localparam month_t MONTH_JUN = 3'd6;

    // last day of year of each month, common year; add one from February on in a leap year
    localparam doy_t END_JAN = 8'd31;
    localparam doy_t END_FEB = 8'd59;
    localparam doy_t END_MAR = 8'd90;
    localparam doy_t END_APR = 8'd120;
    localparam doy_t END_MAY = 8'd151;

    // feast offsets from Easter Sunday, in days
    localparam doy_t CARN_START_OFS = 8'd49;
    localparam doy_t CARN_END_OFS   = 8'd47;
    localparam doy_t GOOD_FRI_OFS   = 8'd2;
    localparam doy_t ASCENSION_OFS  = 8'd39;
    localparam doy_t WHITSUN_OFS    = 8'd49;

    // reciprocals for division by constants: q = (x * MUL) >> SHIFT, exact over the used range
    localparam int DIV100_MUL = 5243;   // shift 19, x < 16384
    localparam int DIV19_MUL  = 55189;  // shift 20, x < 16384
    localparam int DIV25_MUL  = 41;     // shift 10, x < 172
    localparam int DIV3_MUL   = 171;    // shift 9,  x < 165
    localparam int DIV30_MUL  = 2185;   // shift 16, x < 521
    localparam int DIV7_MUL   = 147;    // shift 10, x < 87

endpackage

FILE: design/eafd_md_conv.sv
// Day-of-year to month and day-of-month conversion, January to June.
module eafd_md_conv (
    input  eafd_pkg::doy_t doy_i,
    input  logic           leap_i,
    output eafd_pkg::md_t  md_o
);
    import eafd_pkg::*;

    doy_t   end_feb;
    doy_t   end_mar;
    doy_t   end_apr;
    doy_t   end_may;
    doy_t   month_base;
    month_t month;

    always_comb begin
        end_feb = END_FEB + doy_t'(leap_i);
        end_mar = END_MAR + doy_t'(leap_i);
        end_apr = END_APR + doy_t'(leap_i);
        end_may = END_MAY + doy_t'(leap_i);
        // strictly greater: the last day of a month stays in it
        if (doy_i > end_may) begin
            month      = MONTH_JUN;
            month_base = end_may;
        end else if (doy_i > end_apr) begin
            month      = MONTH_MAY;
            month_base = end_apr;
        end else if (doy_i > end_mar) begin
            month      = MONTH_APR;
            month_base = end_mar;
        end else if (doy_i > end_feb) begin
            month      = MONTH_MAR;
            month_base = end_feb;
        end else if (doy_i > END_JAN) begin
            month      = MONTH_FEB;
            month_base = END_JAN;
        end else begin
            month      = MONTH_JAN;
            month_base = '0;
        end
        md_o.month = month;
        md_o.day   = day_t'(doy_i - month_base);
    end

endmodule

FILE: design/easter_and_feast_dates_core.sv
// Top level: pipelined Easter computus and feast date core.
//
// Usage
//   Slave channel s_*: one word per year, s_tdata[13:0] = year (0..16383),
//   Gregorian, proleptic before 1583. Upper bits of s_tdata are ignored.
//   Master channel m_*: one word per year with the month and day of Easter
//   Sunday, carnival start (-49), carnival end (-47), Good Friday (-2),
//   Ascension (+39) and Whitsuntide (+49).
//   Output: m_tvalid is the valid bit of the last register stage; its word
//   is taken at an edge where m_tready is high.
//   Throughput: one year per cycle while m_tready is high; the eight register
//   stages each carry a valid bit and all move together when the result side takes words.
//   Stall: when m_tready is low the last stage holds its word; earlier stages
//   keep advancing into empty slots, so s_tready stays high until every stage
//   is full. Nothing is dropped or repeated.
//   Reset (aresetn low, synchronous): all valid bits clear, the pipeline is
//   empty and s_tready is high in the first cycle after release.
//   Stages: 1 reciprocal products for /100 and /19, 2 a, b, c, 3 century
//   terms and leap flag, 4 h (mod 30), 5 l (mod 7), 6 day offset of Easter,
//   7 Easter month/day and day of year, 8 feast month/day conversion.
module easter_and_feast_dates_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [13:0] year, [15:14] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // paschal_month[2:0], paschal_day[7:3],
                                   // carnival_start_month[9:8], carnival_start_day[14:10],
                                   // carnival_end_month[16:15], carnival_end_day[21:17],
                                   // good_friday_month[24:22], good_friday_day[29:25],
                                   // ascension_month[32:30], ascension_day_of_month[37:33],
                                   // whitsun_month[40:38], whitsun_day[45:41], [47:46] zero
);
    import eafd_pkg::*;

    localparam int NUM_STAGES = 8;

    // stage control
    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] v_next;
    logic [NUM_STAGES-1:0] en;

    // stage 1
    year_t        s1_y_next,    s1_y_reg;
    logic [26:0]  s1_p100_next, s1_p100_reg;
    logic [29:0]  s1_p19_next,  s1_p19_reg;
    // stage 2
    logic [4:0]   s2_a_next, s2_a_reg;     // year mod 19
    logic [7:0]   s2_b_next, s2_b_reg;     // century
    logic [6:0]   s2_c_next, s2_c_reg;     // year in century
    logic [9:0]   s2_q19;
    // stage 3
    logic [9:0]   s3_hx_next, s3_hx_reg;
    logic [4:0]   s3_a_reg;
    logic [1:0]   s3_e_next,  s3_e_reg;
    logic [4:0]   s3_i_next,  s3_i_reg;
    logic [1:0]   s3_k_next,  s3_k_reg;
    logic         s3_leap_next, s3_leap_reg;
    logic [7:0]   s3_t;
    logic [13:0]  s3_pf;
    logic [2:0]   s3_f;
    logic [7:0]   s3_u;
    logic [15:0]  s3_pg;
    logic [5:0]   s3_g;
    // stage 4
    logic [4:0]   s4_h_next,  s4_h_reg;
    logic [6:0]   s4_lx_next, s4_lx_reg;
    logic [4:0]   s4_a_reg;
    logic         s4_leap_reg;
    logic [21:0]  s4_ph;
    logic [5:0]   s4_qh;
    // stage 5
    logic [2:0]   s5_l_next, s5_l_reg;
    logic [4:0]   s5_h_reg;
    logic [4:0]   s5_a_reg;
    logic         s5_leap_reg;
    logic [14:0]  s5_pl;
    logic [4:0]   s5_ql;
    // stage 6
    logic [7:0]   s6_base_next, s6_base_reg;
    logic         s6_leap_reg;
    logic [9:0]   s6_mx;
    // stage 7
    month_t       s7_em_next,  s7_em_reg;
    day_t         s7_ed_next,  s7_ed_reg;
    doy_t         s7_doy_next, s7_doy_reg;
    logic         s7_leap_reg;
    logic         s7_april;
    // stage 8
    md_t          cs_md, ce_md, gf_md, asc_md, wh_md;
    month_t       s8_em_reg;
    day_t         s8_ed_reg;
    md_t          s8_cs_reg, s8_ce_reg, s8_gf_reg, s8_asc_reg, s8_wh_reg;

    // ---------------------------------------------------------------
    // Flow control: a stage loads when it is empty or its word moves on.
    // ---------------------------------------------------------------
    always_comb begin
        en[NUM_STAGES-1] = !v_reg[NUM_STAGES-1] || m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
        v_next = {v_reg[NUM_STAGES-2:0], s_tvalid};
    end

    assign s_tready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                if (en[k]) begin
                    v_reg[k] <= v_next[k];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Datapath
    // ---------------------------------------------------------------
    always_comb begin
        // stage 1: reciprocal products
        s1_y_next    = s_tdata[YEAR_W-1:0];
        s1_p100_next = 27'(s1_y_next) * 27'(DIV100_MUL);
        s1_p19_next  = 30'(s1_y_next) * 30'(DIV19_MUL);

        // stage 2: a = y mod 19, b = y / 100, c = y mod 100
        s2_b_next = s1_p100_reg[26:19];
        s2_q19    = s1_p19_reg[29:20];
        s2_a_next = 5'(s1_y_reg - 14'(14'(s2_q19) * 14'd19));
        s2_c_next = 7'(s1_y_reg - 14'(s2_b_next) * 14'd100);

        // stage 3: f, g, the sum for h, and the leap flag
        s3_t  = s2_b_reg + 8'd8;
        s3_pf = 14'(s3_t) * 14'(DIV25_MUL);
        s3_f  = s3_pf[12:10];
        s3_u  = s2_b_reg + 8'd1 - 8'(s3_f);
        s3_pg = 16'(s3_u) * 16'(DIV3_MUL);
        s3_g  = s3_pg[14:9];
        s3_hx_next = 10'(s2_a_reg) * 10'd19 + 10'(s2_b_reg) + 10'd15
                   - 10'(s2_b_reg[7:2]) - 10'(s3_g);
        s3_e_next = s2_b_reg[1:0];
        s3_i_next = s2_c_reg[6:2];
        s3_k_next = s2_c_reg[1:0];
        // y mod 4 equals c mod 4; y mod 400 is zero when c and b mod 4 are
        s3_leap_next = (s2_c_reg[1:0] == 2'd0)
                    && !((s2_c_reg == 7'd0) && (s2_b_reg[1:0] != 2'd0));

        // stage 4: h = hx mod 30, then the sum for l
        s4_ph      = 22'(s3_hx_reg) * 22'(DIV30_MUL);
        s4_qh      = s4_ph[21:16];
        s4_h_next  = 5'(s3_hx_reg - 10'(s4_qh) * 10'd30);
        s4_lx_next = 7'd32 + 7'({s3_e_reg, 1'b0}) + 7'({s3_i_reg, 1'b0})
                   - 7'(s4_h_next) - 7'(s3_k_reg);

        // stage 5: l = lx mod 7
        s5_pl     = 15'(s4_lx_reg) * 15'(DIV7_MUL);
        s5_ql     = s5_pl[14:10];
        s5_l_next = 3'(s4_lx_reg - 7'(s5_ql) * 7'd7);

        // stage 6: m is 0 or 1, so the divide by 451 is one compare
        s6_mx        = 10'(s5_a_reg) + 10'(s5_h_reg) * 10'd11 + 10'(s5_l_reg) * 10'd22;
        s6_base_next = 8'(s5_h_reg) + 8'(s5_l_reg) + 8'd114
                     - ((s6_mx >= 10'd451) ? 8'd7 : 8'd0);

        // stage 7: base spans 31*3..31*5-1, so month is 3 or 4
        s7_april    = (s6_base_reg >= 8'd124);
        s7_em_next  = s7_april ? MONTH_APR : MONTH_MAR;
        s7_ed_next  = s7_april ? day_t'(s6_base_reg - 8'd123) : day_t'(s6_base_reg - 8'd92);
        s7_doy_next = doy_t'(s7_ed_next) + (s7_april ? END_MAR : END_FEB)
                    + doy_t'(s6_leap_reg);
    end

    // stage 8: feast dates back to month and day
    eafd_md_conv u_conv_cs (
        .doy_i  (s7_doy_reg - CARN_START_OFS),
        .leap_i (s7_leap_reg),
        .md_o   (cs_md)
    );
    eafd_md_conv u_conv_ce (
        .doy_i  (s7_doy_reg - CARN_END_OFS),
        .leap_i (s7_leap_reg),
        .md_o   (ce_md)
    );
    eafd_md_conv u_conv_gf (
        .doy_i  (s7_doy_reg - GOOD_FRI_OFS),
        .leap_i (s7_leap_reg),
        .md_o   (gf_md)
    );
    eafd_md_conv u_conv_asc (
        .doy_i  (s7_doy_reg + ASCENSION_OFS),
        .leap_i (s7_leap_reg),
        .md_o   (asc_md)
    );
    eafd_md_conv u_conv_wh (
        .doy_i  (s7_doy_reg + WHITSUN_OFS),
        .leap_i (s7_leap_reg),
        .md_o   (wh_md)
    );

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            s1_y_reg    <= s1_y_next;
            s1_p100_reg <= s1_p100_next;
            s1_p19_reg  <= s1_p19_next;
        end
        if (en[1]) begin
            s2_a_reg <= s2_a_next;
            s2_b_reg <= s2_b_next;
            s2_c_reg <= s2_c_next;
        end
        if (en[2]) begin
            s3_hx_reg   <= s3_hx_next;
            s3_a_reg    <= s2_a_reg;
            s3_e_reg    <= s3_e_next;
            s3_i_reg    <= s3_i_next;
            s3_k_reg    <= s3_k_next;
            s3_leap_reg <= s3_leap_next;
        end
        if (en[3]) begin
            s4_h_reg    <= s4_h_next;
            s4_lx_reg   <= s4_lx_next;
            s4_a_reg    <= s3_a_reg;
            s4_leap_reg <= s3_leap_reg;
        end
        if (en[4]) begin
            s5_l_reg    <= s5_l_next;
            s5_h_reg    <= s4_h_reg;
            s5_a_reg    <= s4_a_reg;
            s5_leap_reg <= s4_leap_reg;
        end
        if (en[5]) begin
            s6_base_reg <= s6_base_next;
            s6_leap_reg <= s5_leap_reg;
        end
        if (en[6]) begin
            s7_em_reg   <= s7_em_next;
            s7_ed_reg   <= s7_ed_next;
            s7_doy_reg  <= s7_doy_next;
            s7_leap_reg <= s6_leap_reg;
        end
        if (en[7]) begin
            s8_em_reg  <= s7_em_reg;
            s8_ed_reg  <= s7_ed_reg;
            s8_cs_reg  <= cs_md;
            s8_ce_reg  <= ce_md;
            s8_gf_reg  <= gf_md;
            s8_asc_reg <= asc_md;
            s8_wh_reg  <= wh_md;
        end
    end

    // result word
    assign m_tvalid = v_reg[NUM_STAGES-1];
    assign m_tdata  = {2'b00,
                       s8_wh_reg.day,  s8_wh_reg.month,
                       s8_asc_reg.day, s8_asc_reg.month,
                       s8_gf_reg.day,  s8_gf_reg.month,
                       s8_ce_reg.day,  s8_ce_reg.month[1:0],
                       s8_cs_reg.day,  s8_cs_reg.month[1:0],
                       s8_ed_reg,      s8_em_reg};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // input held back only when every stage is occupied
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (&v_reg))
        else $error("s_tready low with an empty pipeline stage");

    // Good Friday two days before Easter within the same month
    a_good_friday: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[7:3] >= 5'd3))
            |-> ((m_tdata[24:22] == m_tdata[2:0]) && (m_tdata[29:25] == m_tdata[7:3] - 5'd2)))
        else $error("Good Friday does not match Easter");

    // carnival end two days after carnival start
    a_carnival: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[14:10] <= 5'd26))
            |-> ((m_tdata[16:15] == m_tdata[9:8]) && (m_tdata[21:17] == m_tdata[14:10] + 5'd2)))
        else $error("carnival end does not follow carnival start");

endmodule
